// File: hw/rtl/mkt_pkg.sv
package mkt_pkg;

	// Field and register widths.
	localparam int unsigned UNIT_W   = 12;
	localparam int unsigned SETTLE_W = 8;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 12;

	// Scaled comparison width: ten times the largest phase count.
	localparam int unsigned SCALED_W = 20;

	// Reset values and limits.
	localparam logic [UNIT_W-1:0]   UNIT_RESET   = 12'd100;
	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd5;
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = 16'hFFFF;
	localparam logic [SETTLE_W-1:0] SETTLE_MAX   = 8'hFF;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 1'd1;

	// Reported symbol codes.
	typedef enum logic [1:0] {
		SYM_GAP  = 2'd0,
		SYM_DOT  = 2'd1,
		SYM_DASH = 2'd2,
		SYM_UNCL = 2'd3
	} symbol_t;

endpackage

// File: hw/rtl/mkt_key_if.sv
interface mkt_key_if;

	logic valid;
	logic ready;
	logic key_level;

	modport source (output valid, output key_level, input ready);
	modport sink (input valid, input key_level, output ready);

endinterface

// File: hw/rtl/mkt_sym_if.sv
interface mkt_sym_if;

	logic                          valid;
	logic                          ready;
	mkt_pkg::symbol_t              symbol;
	logic                          ended_pressed;
	logic [mkt_pkg::COUNT_W-1:0]   phase_ticks;

	modport source (output valid, output symbol, output ended_pressed, output phase_ticks,
		input ready);
	modport sink (input valid, input symbol, input ended_pressed, input phase_ticks,
		output ready);

endinterface

// File: hw/rtl/morse_key_timing_classifier_top.sv
// A key sample passes through the input register, and its result, if any, through the result register.
// One sample per cycle while no stall holds it; the debounce state and the phase counter are
// updated in a single stage, from the input register.
// A full result register with a stalled consumer holds back only a sample that ends a phase.
// Reset (arst_n low, asynchronous): key released, counters cleared, not confirming,
// unit 100 ticks, settle 5 ticks, no result pending.
module morse_key_timing_classifier_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mkt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mkt_pkg::CFG_DATA_W-1:0]  cfg_data,
	mkt_key_if.sink                         key,
	mkt_sym_if.source                       sym
);
	import mkt_pkg::*;

	// Configuration registers.
	logic [UNIT_W-1:0]   unit_ticks_q;
	logic [SETTLE_W-1:0] settle_ticks_q;

	// Input register.
	logic key_vld_s1;
	logic key_level_s1;

	// Debounce and phase state.
	logic                stable_level_q;
	logic [COUNT_W-1:0]  phase_count_q;
	logic                confirming_q;
	logic [SETTLE_W-1:0] settle_count_q;

	// Result register.
	logic               sym_vld_q;
	symbol_t            symbol_q;
	logic               ended_pressed_q;
	logic [COUNT_W-1:0] phase_ticks_q;

	// Stage logic.
	logic                phase_inc;
	logic [COUNT_W-1:0]  phase_next;
	logic [SETTLE_W-1:0] settle_next;
	logic                check;
	logic                differs;
	logic                emit;
	logic                advance;
	logic [SCALED_W-1:0] scaled;
	logic [SCALED_W-1:0] lim_7;
	logic [SCALED_W-1:0] lim_13;
	logic [SCALED_W-1:0] lim_21;
	logic [SCALED_W-1:0] lim_39;
	logic                in_dash_win;
	logic                in_dot_win;
	symbol_t             symbol_d;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q   <= UNIT_RESET;
			settle_ticks_q <= SETTLE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UNIT:   unit_ticks_q   <= cfg_data[UNIT_W-1:0];
				CFG_SETTLE: settle_ticks_q <= cfg_data[SETTLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturating counters and the confirmation check.
	assign phase_inc   = (phase_count_q != COUNT_MAX);
	assign phase_next  = phase_count_q + COUNT_W'(phase_inc);
	assign settle_next = (settle_count_q == SETTLE_MAX) ? settle_count_q
		: settle_count_q + SETTLE_W'(1);
	assign differs = (key_level_s1 != stable_level_q);
	assign check   = confirming_q && (settle_next >= settle_ticks_q);
	assign emit    = check && differs;

	// The sample moves on unless it ends a phase and the result register cannot take it.
	assign advance   = key_vld_s1 && (!emit || !sym_vld_q || sym.ready);
	assign key.ready = !key_vld_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_vld_s1 <= 1'b0;
		end else if (key.ready) begin
			key_vld_s1 <= key.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key.ready) begin
			key_level_s1 <= key.key_level;
		end
	end

	// Debounce state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_level_q <= 1'b1;
			phase_count_q  <= '0;
			confirming_q   <= 1'b0;
			settle_count_q <= '0;
		end else if (advance) begin
			phase_count_q <= emit ? '0 : phase_next;
			if (!confirming_q) begin
				if (differs) begin
					confirming_q   <= 1'b1;
					settle_count_q <= '0;
				end
			end else if (check) begin
				confirming_q   <= 1'b0;
				settle_count_q <= '0;
				if (differs) begin
					stable_level_q <= key_level_s1;
				end
			end else begin
				settle_count_q <= settle_next;
			end
		end
	end

	// Classification: ten times the length against 7, 13, 21 and 39 units.
	always_comb begin
		scaled = {1'b0, phase_next, 3'b000} + {3'b000, phase_next, 1'b0};
		lim_7  = SCALED_W'({unit_ticks_q, 3'b000}) - SCALED_W'(unit_ticks_q);
		lim_13 = SCALED_W'({unit_ticks_q, 4'b0000}) - SCALED_W'({unit_ticks_q, 1'b0})
			- SCALED_W'(unit_ticks_q);
		lim_21 = SCALED_W'({unit_ticks_q, 4'b0000}) + SCALED_W'({unit_ticks_q, 2'b00})
			+ SCALED_W'(unit_ticks_q);
		lim_39 = SCALED_W'({unit_ticks_q, 5'b00000}) + SCALED_W'({unit_ticks_q, 3'b000})
			- SCALED_W'(unit_ticks_q);
		in_dash_win = (scaled > lim_21) && (scaled < lim_39);
		in_dot_win  = (scaled > lim_7) && (scaled < lim_13);
		if (stable_level_q == 1'b0) begin
			if (in_dash_win) begin
				symbol_d = SYM_DASH;
			end else if (in_dot_win) begin
				symbol_d = SYM_DOT;
			end else begin
				symbol_d = SYM_UNCL;
			end
		end else begin
			symbol_d = in_dash_win ? SYM_GAP : SYM_UNCL;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_vld_q <= 1'b0;
		end else if (advance && emit) begin
			sym_vld_q <= 1'b1;
		end else if (sym.ready) begin
			sym_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			symbol_q        <= symbol_d;
			ended_pressed_q <= ~stable_level_q;
			phase_ticks_q   <= phase_next;
		end
	end

	assign sym.valid         = sym_vld_q;
	assign sym.symbol        = symbol_q;
	assign sym.ended_pressed = ended_pressed_q;
	assign sym.phase_ticks   = phase_ticks_q;

	// A result only ever comes out of a confirmation in progress.
	a_emit_needs_confirm: assert property (@(posedge clk) disable iff (!arst_n)
		(key_vld_s1 && emit) |-> confirming_q)
		else $error("result raised outside a confirmation");

	// The settle counter is idle whenever no change is being confirmed.
	a_settle_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!confirming_q |-> (settle_count_q == '0))
		else $error("settle counter running while not confirming");

	// An accepted edge flips the stable level and restarts the phase count.
	a_edge_update: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (phase_count_q == '0) && (stable_level_q != $past(stable_level_q))
			&& sym_vld_q)
		else $error("accepted edge did not update state and result");

	// With the result register empty, samples are never held back.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!sym_vld_q |-> key.ready)
		else $error("input stalled with an empty result register");

	// Outside an accepted edge the phase count does not fall back to zero.
	a_phase_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !emit && (phase_count_q != '0)) |=> (phase_count_q != '0))
		else $error("phase count restarted without an accepted edge");

endmodule
